### hw/rtl/vfa_pkg.sv
// Shared types, constants and the clamp helper for the fixed-point vector ALU.
`default_nettype none

package vfa_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned PROD_W    = 2 * (DATA_W + 1);
   localparam int unsigned WIDE_W    = PROD_W + 2;
   localparam int unsigned SQ_W      = 2 * DATA_W;
   localparam int unsigned ROOT_W    = DATA_W;
   localparam int unsigned NUM_LANES = 3;
   localparam int unsigned ACT_W     = 4;

   typedef enum logic [ACT_W-1:0] {
      OP_ADD       = 4'd0,
      OP_SUB       = 4'd1,
      OP_SCALE     = 4'd2,
      OP_DIVIDE    = 4'd3,
      OP_DOT       = 4'd4,
      OP_CROSS     = 4'd5,
      OP_MAGNITUDE = 4'd6,
      OP_NORMALIZE = 4'd7,
      OP_DISTANCE  = 4'd8,
      OP_NEGATE    = 4'd9,
      OP_EQUAL     = 4'd10
   } op_type;

   typedef logic signed [DATA_W-1:0] data_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic               sat;
      data_type           val;
   } clamp_type;

   // Operands held while the lanes do their work.
   typedef struct packed {
      logic [ACT_W-1:0]   act;
      data_type           ax;
      data_type           ay;
      data_type           az;
      data_type           s;
      logic               eq;
   } pre_type;

   // What one lane hands to the merge stage.
   typedef struct packed {
      data_type                  val;
      logic                      sat;
      logic                      big;
      logic signed [PROD_W-1:0]  prod;
   } lane_out_type;

   // Partial result carried alongside the root and divide pipelines.
   typedef struct packed {
      logic [ACT_W-1:0]   act;
      data_type           rx;
      data_type           ry;
      data_type           rz;
      data_type           sc;
      logic               eq;
      logic               sat;
      logic               big;
      data_type           ax;
      data_type           ay;
      data_type           az;
      data_type           s;
   } rec_type;

   // Clamp a wide signed value into the data range.
   function automatic clamp_type clamp_wide(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-DATA_W:0] top_bits;
      clamp_type              res;
      top_bits = v[WIDE_W-1:DATA_W-1];
      if ((&top_bits) || (~|top_bits)) begin
         res.sat = 1'b0;
         res.val = v[DATA_W-1:0];
      end else begin
         res.sat = 1'b1;
         res.val = v[WIDE_W-1] ? DATA_MIN : DATA_MAX;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/vfa_req_if.sv
// Request channel: operation code, vectors A and B and the scalar.
`default_nettype none

interface vfa_req_if;
   import vfa_pkg::*;

   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   data_type         ax;
   data_type         ay;
   data_type         az;
   data_type         bx;
   data_type         by;
   data_type         bz;
   data_type         scalar_in;

   modport source (output valid, action, ax, ay, az, bx, by, bz, scalar_in, input ready);
   modport sink   (input valid, action, ax, ay, az, bx, by, bz, scalar_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/vfa_rsp_if.sv
// Response channel: vector result, scalar result and status bits.
`default_nettype none

interface vfa_rsp_if;
   import vfa_pkg::*;

   logic     valid;
   logic     ready;
   data_type rx;
   data_type ry;
   data_type rz;
   data_type scalar_out;
   logic     is_equal;
   logic     saturated;

   modport source (output valid, rx, ry, rz, scalar_out, is_equal, saturated, input ready);
   modport sink   (input valid, rx, ry, rz, scalar_out, is_equal, saturated, output ready);
endinterface

`default_nettype wire

### hw/rtl/vec3_fixed_alu.sv
// Top level of the three-component fixed-point vector ALU.
`default_nettype none

// Channel   Direction  Word contents
// req_bus   in         action, vector A (ax, ay, az), vector B (bx, by, bz), scalar_in
// rsp_bus   out        vector rx, ry, rz, scalar_out, is_equal, saturated
//
// One word is accepted every clock cycle unless the output stalls; each yields exactly
// one response word (Q16.16 at FRAC_BITS = 16). The path has three lane stages, one merge
// stage, 32 square-root stages, 32 + FRAC_BITS divider stages and the output register.
// Every operation takes the same path length, so responses leave in request order.
// Reset is synchronous and clears only the valid bits of the pipeline.
// A response held on rsp_bus stalls the whole pipeline, and req_bus.ready drops with
// it even when earlier stages hold bubbles.

module vec3_fixed_alu #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   vfa_req_if.sink   req_bus,
   vfa_rsp_if.source rsp_bus
);
   import vfa_pkg::*;

   localparam int unsigned QUO_W     = DATA_W + FRAC_BITS;
   localparam int unsigned PRE_DEPTH = 3;
   localparam int unsigned LAT       = PRE_DEPTH + 1 + ROOT_W + QUO_W + 1;

   localparam logic [QUO_W-1:0] Q_LIM_POS = QUO_W'({1'b0, {(DATA_W-1){1'b1}}});
   localparam logic [QUO_W-1:0] Q_LIM_NEG = QUO_W'({1'b1, {(DATA_W-1){1'b0}}});

   typedef struct packed {
      rec_type           rec;
      logic [ROOT_W-1:0] root;
   } recroot_type;

   typedef struct packed {
      data_type rx;
      data_type ry;
      data_type rz;
      data_type sc;
      logic     eq;
      logic     sat;
   } res_type;

   // Divider quotient magnitude and sign to a clamped signed result.
   function automatic clamp_type quo_clamp(input logic [QUO_W-1:0] q, input logic neg);
      clamp_type res;
      if (neg) begin
         res.sat = q > Q_LIM_NEG;
         res.val = res.sat ? DATA_MIN : (DATA_W'(0) - q[DATA_W-1:0]);
      end else begin
         res.sat = q > Q_LIM_POS;
         res.val = res.sat ? DATA_MAX : q[DATA_W-1:0];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Flow control: the whole pipeline moves together unless the output
   // register holds a word that has not been taken.
   // ------------------------------------------------------------------
   logic           adv;
   logic           req_fire;
   logic [LAT-1:0] vld_ff, vld_in;

   assign adv           = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign req_fire      = req_bus.valid && adv;
   assign vld_in        = {vld_ff[LAT-2:0], req_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------------
   // Lanes: one per component, each with its own multipliers.
   // ------------------------------------------------------------------
   data_type     a_arr [NUM_LANES];
   data_type     b_arr [NUM_LANES];
   lane_out_type lane_res [NUM_LANES];

   assign a_arr[0] = req_bus.ax;
   assign a_arr[1] = req_bus.ay;
   assign a_arr[2] = req_bus.az;
   assign b_arr[0] = req_bus.bx;
   assign b_arr[1] = req_bus.by;
   assign b_arr[2] = req_bus.bz;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      vfa_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .en       (adv),
         .act      (req_bus.action),
         .a_self   (a_arr[i]),
         .b_self   (b_arr[i]),
         .a_next   (a_arr[(i + 1) % NUM_LANES]),
         .b_next   (b_arr[(i + 1) % NUM_LANES]),
         .a_last   (a_arr[(i + 2) % NUM_LANES]),
         .b_last   (b_arr[(i + 2) % NUM_LANES]),
         .scalar   (req_bus.scalar_in),
         .lane_out (lane_res[i])
      );
   end

   // Operands and the equality test ride beside the lanes.
   pre_type pre_in, pre_d;

   always_comb begin
      pre_in.act = req_bus.action;
      pre_in.ax  = req_bus.ax;
      pre_in.ay  = req_bus.ay;
      pre_in.az  = req_bus.az;
      pre_in.s   = req_bus.scalar_in;
      pre_in.eq  = (req_bus.ax == req_bus.bx) && (req_bus.ay == req_bus.by) &&
                   (req_bus.az == req_bus.bz);
   end

   vfa_delay #(
      .WIDTH ($bits(pre_type)),
      .DEPTH (PRE_DEPTH)
   ) u_pre_dly (
      .clock (clock),
      .en    (adv),
      .din   (pre_in),
      .dout  (pre_d)
   );

   // ------------------------------------------------------------------
   // Merge stage: the lane products add up to the dot product or to the
   // sum of squares that feeds the root.
   // ------------------------------------------------------------------
   logic signed [WIDE_W-1:0] prod_sum;
   clamp_type                dot_cl;
   rec_type                  rec_in, rec_ff;
   logic [SQ_W-1:0]          sumsq_in, sumsq_ff;

   always_comb begin
      prod_sum = WIDE_W'(lane_res[0].prod) + WIDE_W'(lane_res[1].prod) +
                 WIDE_W'(lane_res[2].prod);
      dot_cl   = clamp_wide(prod_sum >>> FRAC_BITS);
      sumsq_in = prod_sum[SQ_W-1:0];
      rec_in.act = pre_d.act;
      rec_in.rx  = lane_res[0].val;
      rec_in.ry  = lane_res[1].val;
      rec_in.rz  = lane_res[2].val;
      rec_in.sc  = '0;
      rec_in.eq  = 1'b0;
      rec_in.sat = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
      rec_in.big = lane_res[0].big | lane_res[1].big | lane_res[2].big;
      rec_in.ax  = pre_d.ax;
      rec_in.ay  = pre_d.ay;
      rec_in.az  = pre_d.az;
      rec_in.s   = pre_d.s;
      case (pre_d.act)
         OP_DOT: begin
            rec_in.sc  = dot_cl.val;
            rec_in.sat = dot_cl.sat;
         end
         OP_EQUAL: rec_in.eq = pre_d.eq;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rec_ff   <= rec_in;
         sumsq_ff <= sumsq_in;
      end
   end

   // ------------------------------------------------------------------
   // Square root of the sum of squares.
   // ------------------------------------------------------------------
   logic [ROOT_W-1:0] root_sq;
   rec_type           rec_sq;

   vfa_isqrt u_isqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (sumsq_ff),
      .root     (root_sq)
   );

   vfa_delay #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (ROOT_W)
   ) u_sq_dly (
      .clock (clock),
      .en    (adv),
      .din   (rec_ff),
      .dout  (rec_sq)
   );

   // ------------------------------------------------------------------
   // Dividers, one per lane: A * 2^FRAC_BITS over the scalar (divide) or
   // over the magnitude (normalize), in sign and magnitude form.
   // ------------------------------------------------------------------
   data_type          a_sq [NUM_LANES];
   logic [DATA_W-1:0] s_mag, dsr;
   logic [QUO_W-1:0]  quo [NUM_LANES];
   logic              qneg [NUM_LANES];
   recroot_type       rr_in, rr_dv;

   assign a_sq[0] = rec_sq.ax;
   assign a_sq[1] = rec_sq.ay;
   assign a_sq[2] = rec_sq.az;
   assign s_mag   = rec_sq.s[DATA_W-1] ? DATA_W'(-rec_sq.s) : rec_sq.s;
   assign dsr     = (rec_sq.act == OP_NORMALIZE) ? root_sq : s_mag;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_div
      logic [DATA_W-1:0] a_mag;
      logic              neg;

      assign a_mag = a_sq[i][DATA_W-1] ? DATA_W'(-a_sq[i]) : a_sq[i];
      assign neg   = a_sq[i][DATA_W-1] ^
                     ((rec_sq.act == OP_DIVIDE) && rec_sq.s[DATA_W-1]);

      vfa_div #(
         .FRAC_BITS (FRAC_BITS)
      ) u_div (
         .clock    (clock),
         .en       (adv),
         .dividend ({a_mag, {FRAC_BITS{1'b0}}}),
         .divisor  (dsr),
         .negate   (neg),
         .quotient (quo[i]),
         .quot_neg (qneg[i])
      );
   end

   assign rr_in.rec  = rec_sq;
   assign rr_in.root = root_sq;

   vfa_delay #(
      .WIDTH ($bits(recroot_type)),
      .DEPTH (QUO_W)
   ) u_dv_dly (
      .clock (clock),
      .en    (adv),
      .din   (rr_in),
      .dout  (rr_dv)
   );

   // ------------------------------------------------------------------
   // Final selection into the output register. Scalar-only and unused
   // codes already carry zero vector components from the lanes.
   // ------------------------------------------------------------------
   clamp_type cq [NUM_LANES];
   clamp_type root_cl;
   res_type   out_in, out_ff;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_qcl
      assign cq[i] = quo_clamp(quo[i], qneg[i]);
   end

   always_comb begin
      root_cl.sat = rr_dv.root[ROOT_W-1];
      root_cl.val = root_cl.sat ? DATA_MAX : rr_dv.root;
      out_in.rx  = rr_dv.rec.rx;
      out_in.ry  = rr_dv.rec.ry;
      out_in.rz  = rr_dv.rec.rz;
      out_in.sc  = rr_dv.rec.sc;
      out_in.eq  = rr_dv.rec.eq;
      out_in.sat = rr_dv.rec.sat;
      case (rr_dv.rec.act)
         OP_DIVIDE: begin
            // A zero divisor leaves the zero vector from the lanes.
            if (rr_dv.rec.s != '0) begin
               out_in.rx  = cq[0].val;
               out_in.ry  = cq[1].val;
               out_in.rz  = cq[2].val;
               out_in.sat = cq[0].sat | cq[1].sat | cq[2].sat;
            end
         end
         OP_NORMALIZE: begin
            // A zero magnitude only comes from the zero vector, which is returned as is.
            if (rr_dv.root != '0) begin
               out_in.rx  = cq[0].val;
               out_in.ry  = cq[1].val;
               out_in.rz  = cq[2].val;
               out_in.sc  = root_cl.val;
               out_in.sat = cq[0].sat | cq[1].sat | cq[2].sat | root_cl.sat;
            end
         end
         OP_MAGNITUDE: begin
            out_in.sc  = root_cl.val;
            out_in.sat = root_cl.sat;
         end
         OP_DISTANCE: begin
            if (rr_dv.rec.big) begin
               out_in.sc  = DATA_MAX;
               out_in.sat = 1'b1;
            end else begin
               out_in.sc  = root_cl.val;
               out_in.sat = root_cl.sat;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid      = vld_ff[LAT-1];
   assign rsp_bus.rx         = out_ff.rx;
   assign rsp_bus.ry         = out_ff.ry;
   assign rsp_bus.rz         = out_ff.rz;
   assign rsp_bus.scalar_out = out_ff.sc;
   assign rsp_bus.is_equal   = out_ff.eq;
   assign rsp_bus.saturated  = out_ff.sat;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // An equality word carries nothing but the equality bit.
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_equal |->
         !rsp_bus.saturated && (rsp_bus.scalar_out == '0) &&
         (rsp_bus.rx == '0) && (rsp_bus.ry == '0) && (rsp_bus.rz == '0))
      else $error("equality response carries other results");

   // While the output is stalled no word may move or vanish in the pipeline.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (vld_ff == $past(vld_ff)))
      else $error("pipeline moved during a stall");

   // A word taken from the request side enters the first stage.
   a_fire_enter: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> vld_ff[0])
      else $error("accepted request word lost at entry");

   // A stalled output keeps its word valid.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && !req_bus.ready ||
         rsp_bus.valid && rsp_bus.ready)
      else $error("response word dropped while stalled");

endmodule

`default_nettype wire

### hw/rtl/vfa_delay.sv
// Enabled shift line that keeps side data aligned with a pipelined unit.
`default_nettype none

module vfa_delay #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   for (genvar j = 0; j < DEPTH; j++) begin : g_tap
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               tap_ff[0] <= din;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               tap_ff[j] <= tap_ff[j-1];
            end
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

### hw/rtl/vfa_lane.sv
// One component lane: operand select, multipliers and per-component results.
`default_nettype none

module vfa_lane #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [vfa_pkg::ACT_W-1:0]      act,
   input  vfa_pkg::data_type              a_self,
   input  vfa_pkg::data_type              b_self,
   input  vfa_pkg::data_type              a_next,
   input  vfa_pkg::data_type              b_next,
   input  vfa_pkg::data_type              a_last,
   input  vfa_pkg::data_type              b_last,
   input  vfa_pkg::data_type              scalar,
   output vfa_pkg::lane_out_type          lane_out
);
   import vfa_pkg::*;

   logic [ACT_W-1:0]          act1_ff, act2_ff;
   logic signed [DATA_W:0]    diff;
   logic signed [DATA_W:0]    opa_in, opb_in, opc_in, opd_in;
   logic signed [DATA_W:0]    opa_ff, opb_ff, opc_ff, opd_ff;
   logic signed [DATA_W+1:0]  simp_in, simp1_ff, simp2_ff;
   logic                      big_in, big1_ff, big2_ff;
   logic signed [PROD_W-1:0]  p1_ff, p2_ff;
   logic signed [WIDE_W-1:0]  w_prod, w_diff;
   clamp_type                 cl;
   lane_out_type              out_in, out_ff;

   // Operand selection. The difference B - A feeds the distance squares.
   always_comb begin
      diff   = (DATA_W+1)'(b_self) - (DATA_W+1)'(a_self);
      big_in = (diff[DATA_W] != diff[DATA_W-1]) ||
               (diff == {2'b11, {(DATA_W-1){1'b0}}});
      opa_in = (DATA_W+1)'(a_self);
      opb_in = (DATA_W+1)'(b_self);
      opc_in = '0;
      opd_in = '0;
      simp_in = '0;
      case (act)
         OP_ADD:    simp_in = (DATA_W+2)'(a_self) + (DATA_W+2)'(b_self);
         OP_SUB:    simp_in = (DATA_W+2)'(a_self) - (DATA_W+2)'(b_self);
         OP_NEGATE: simp_in = -(DATA_W+2)'(a_self);
         OP_SCALE:  opb_in  = (DATA_W+1)'(scalar);
         OP_CROSS: begin
            opa_in = (DATA_W+1)'(a_next);
            opb_in = (DATA_W+1)'(b_last);
            opc_in = (DATA_W+1)'(a_last);
            opd_in = (DATA_W+1)'(b_next);
         end
         OP_MAGNITUDE, OP_NORMALIZE: opb_in = (DATA_W+1)'(a_self);
         OP_DISTANCE: begin
            opa_in = diff;
            opb_in = diff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act1_ff  <= act;
         opa_ff   <= opa_in;
         opb_ff   <= opb_in;
         opc_ff   <= opc_in;
         opd_ff   <= opd_in;
         simp1_ff <= simp_in;
         big1_ff  <= big_in;
         act2_ff  <= act1_ff;
         p1_ff    <= opa_ff * opb_ff;
         p2_ff    <= opc_ff * opd_ff;
         simp2_ff <= simp1_ff;
         big2_ff  <= big1_ff;
         out_ff   <= out_in;
      end
   end

   // Arithmetic shift of the exact product floors toward minus infinity.
   always_comb begin
      w_prod = WIDE_W'(p1_ff) >>> FRAC_BITS;
      w_diff = (WIDE_W'(p1_ff) - WIDE_W'(p2_ff)) >>> FRAC_BITS;
      cl     = '0;
      case (act2_ff)
         OP_ADD, OP_SUB, OP_NEGATE: cl = clamp_wide(WIDE_W'(simp2_ff));
         OP_SCALE:                  cl = clamp_wide(w_prod);
         OP_CROSS:                  cl = clamp_wide(w_diff);
         default: begin
         end
      endcase
      out_in.val  = cl.val;
      out_in.sat  = cl.sat;
      out_in.big  = big2_ff;
      out_in.prod = p1_ff;
   end

   assign lane_out = out_ff;

endmodule

`default_nettype wire

### hw/rtl/vfa_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module vfa_isqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [vfa_pkg::SQ_W-1:0]     radicand,
   output logic [vfa_pkg::ROOT_W-1:0]   root
);
   import vfa_pkg::*;

   logic [SQ_W-1:0]   rem_ff [ROOT_W];
   logic [ROOT_W-1:0] res_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      localparam int unsigned K = ROOT_W - 1 - j;
      logic [SQ_W-1:0]   rem_prev, rem_in;
      logic [ROOT_W-1:0] res_prev, res_in;
      logic [SQ_W:0]     trial;
      logic              fits;

      if (j == 0) begin : g_first
         assign rem_prev = radicand;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      // Try setting bit K: (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K).
      always_comb begin
         trial  = ((SQ_W+1)'(res_prev) << (K + 1)) + ((SQ_W+1)'(1) << (2 * K));
         fits   = {1'b0, rem_prev} >= trial;
         rem_in = fits ? SQ_W'({1'b0, rem_prev} - trial) : rem_prev;
         res_in = fits ? (res_prev | (ROOT_W'(1) << K)) : res_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            res_ff[j] <= res_in;
         end
      end
   end

   assign root = res_ff[ROOT_W-1];

endmodule

`default_nettype wire

### hw/rtl/vfa_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none

module vfa_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [vfa_pkg::DATA_W+FRAC_BITS-1:0]   dividend,
   input  logic [vfa_pkg::DATA_W-1:0]             divisor,
   input  logic                                   negate,
   output logic [vfa_pkg::DATA_W+FRAC_BITS-1:0]   quotient,
   output logic                                   quot_neg
);
   import vfa_pkg::*;

   localparam int unsigned QUO_W = DATA_W + FRAC_BITS;

   logic [DATA_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0]  nq_ff  [QUO_W];
   logic [DATA_W-1:0] dsr_ff [QUO_W];
   logic              neg_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      logic [DATA_W-1:0] rem_prev, dsr_prev, rem_in;
      logic [QUO_W-1:0]  nq_prev, nq_in;
      logic              neg_prev;
      logic [DATA_W:0]   trial;
      logic              fits;

      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = dividend;
         assign dsr_prev = divisor;
         assign neg_prev = negate;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign nq_prev  = nq_ff[j-1];
         assign dsr_prev = dsr_ff[j-1];
         assign neg_prev = neg_ff[j-1];
      end

      // The dividend shifts out at the top while quotient bits enter below.
      always_comb begin
         trial  = {rem_prev, nq_prev[QUO_W-1]};
         fits   = trial >= {1'b0, dsr_prev};
         rem_in = fits ? DATA_W'(trial - {1'b0, dsr_prev}) : trial[DATA_W-1:0];
         nq_in  = {nq_prev[QUO_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            nq_ff[j]  <= nq_in;
            dsr_ff[j] <= dsr_prev;
            neg_ff[j] <= neg_prev;
         end
      end
   end

   assign quotient = nq_ff[QUO_W-1];
   assign quot_neg = neg_ff[QUO_W-1];

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the fixed-point vector ALU: directed cases, random words, stalls.
`timescale 1ns / 100ps

module tb_top;
   import vfa_pkg::*;

   localparam int unsigned FRAC       = 16;
   localparam int          IDLE_LIMIT = 5000;    // cycles with no word moving on either side
   localparam int          LONG_HOLD  = 400;     // receiver hold-off, longer than the pipeline
   localparam int          DRAIN_WAIT = 120;     // extra wait once every expected word is back

   typedef logic signed [71:0] wide_type;

   // One request word and the response word it should produce.
   typedef struct {
      logic [ACT_W-1:0] act;
      data_type         ax, ay, az, bx, by, bz, s;
   } vec_word_type;

   typedef struct {
      data_type rx, ry, rz, sc;
      logic     eq, sat;
   } vec_result_type;

   logic clock;
   logic reset;

   vfa_req_if req ();
   vfa_rsp_if rsp ();

   vec3_fixed_alu #(.FRAC_BITS(FRAC)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   vec_result_type pending_results[$];
   int          mismatches  = 0;
   int          words_sent  = 0;
   int          words_back  = 0;
   int          op_hits[16];
   int          sat_seen    = 0;
   int          burst_left  = 0;
   int          hold_asks   = 0;
   int          hold_done   = 0;
   int          hold_cnt    = 0;
   int          rx_mode     = 0;
   int          rx_mode_left = 0;
   int          idle_cycles = 0;

   // ------------------------------------------------------------------
   // Prediction. All arithmetic is carried out exactly in 72 signed bits,
   // which holds every sum of three 64-bit products without wrapping.
   // ------------------------------------------------------------------

   // Clamp into the 32-bit signed range and note whether clamping happened.
   function automatic data_type clamp_q(input wide_type v, inout logic flag);
      if (v > 72'sd2147483647) begin
         flag = 1'b1;
         return DATA_MAX;
      end
      if (v < -72'sd2147483648) begin
         flag = 1'b1;
         return DATA_MIN;
      end
      return v[31:0];
   endfunction

   // Truncating integer square root, bit by bit.
   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = n;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic vec_result_type compute_vector_op(input vec_word_type w);
      wide_type       a[3];
      wide_type       b[3];
      wide_type       d[3];
      wide_type       s;
      wide_type       acc;
      wide_type       mag;
      logic [63:0]    sum_sq;
      logic           big;
      vec_result_type r;
      a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
      b[0] = w.bx; b[1] = w.by; b[2] = w.bz;
      s    = w.s;
      r    = '{default: '0};
      case (w.act)
         OP_ADD: begin
            r.rx = clamp_q(a[0] + b[0], r.sat);
            r.ry = clamp_q(a[1] + b[1], r.sat);
            r.rz = clamp_q(a[2] + b[2], r.sat);
         end
         OP_SUB: begin
            r.rx = clamp_q(a[0] - b[0], r.sat);
            r.ry = clamp_q(a[1] - b[1], r.sat);
            r.rz = clamp_q(a[2] - b[2], r.sat);
         end
         OP_SCALE: begin
            // Arithmetic shift of a signed value rounds toward minus infinity.
            r.rx = clamp_q((a[0] * s) >>> FRAC, r.sat);
            r.ry = clamp_q((a[1] * s) >>> FRAC, r.sat);
            r.rz = clamp_q((a[2] * s) >>> FRAC, r.sat);
         end
         OP_DIVIDE: begin
            // A zero divisor leaves the zero vector and no flag.
            if (s != 0) begin
               r.rx = clamp_q((a[0] <<< FRAC) / s, r.sat);
               r.ry = clamp_q((a[1] <<< FRAC) / s, r.sat);
               r.rz = clamp_q((a[2] <<< FRAC) / s, r.sat);
            end
         end
         OP_DOT: begin
            acc  = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            r.sc = clamp_q(acc >>> FRAC, r.sat);
         end
         OP_CROSS: begin
            r.rx = clamp_q((a[1] * b[2] - a[2] * b[1]) >>> FRAC, r.sat);
            r.ry = clamp_q((a[2] * b[0] - a[0] * b[2]) >>> FRAC, r.sat);
            r.rz = clamp_q((a[0] * b[1] - a[1] * b[0]) >>> FRAC, r.sat);
         end
         OP_MAGNITUDE: begin
            acc    = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            sum_sq = acc[63:0];
            mag    = {8'd0, int_sqrt(sum_sq)};
            r.sc   = clamp_q(mag, r.sat);
         end
         OP_NORMALIZE: begin
            acc    = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            sum_sq = acc[63:0];
            mag    = {8'd0, int_sqrt(sum_sq)};
            if (mag == 0) begin
               // The zero vector passes through untouched.
               r.rx = w.ax;
               r.ry = w.ay;
               r.rz = w.az;
            end else begin
               // The divisor is the full magnitude even when scalar_out clamps.
               r.rx = clamp_q((a[0] <<< FRAC) / mag, r.sat);
               r.ry = clamp_q((a[1] <<< FRAC) / mag, r.sat);
               r.rz = clamp_q((a[2] <<< FRAC) / mag, r.sat);
               r.sc = clamp_q(mag, r.sat);
            end
         end
         OP_DISTANCE: begin
            big = 1'b0;
            for (int i = 0; i < 3; i++) begin
               d[i] = b[i] - a[i];
               if (d[i] >= 72'sd2147483648 || d[i] <= -72'sd2147483648) big = 1'b1;
            end
            if (big) begin
               r.sc  = DATA_MAX;
               r.sat = 1'b1;
            end else begin
               acc    = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
               sum_sq = acc[63:0];
               mag    = {8'd0, int_sqrt(sum_sq)};
               r.sc   = clamp_q(mag, r.sat);
            end
         end
         OP_NEGATE: begin
            r.rx = clamp_q(-a[0], r.sat);
            r.ry = clamp_q(-a[1], r.sat);
            r.rz = clamp_q(-a[2], r.sat);
         end
         OP_EQUAL: begin
            r.eq = (w.ax == w.bx) && (w.ay == w.by) && (w.az == w.bz);
         end
         default: begin
            // Codes past the last operation give an all-zero word.
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sending side. The sender works in bursts; valid stays high from one
   // word to the next inside a burst and drops only for a gap.
   // ------------------------------------------------------------------
   task automatic send_word(input vec_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req.valid     <= 1'b1;
      req.action    <= w.act;
      req.ax        <= w.ax;
      req.ay        <= w.ay;
      req.az        <= w.az;
      req.bx        <= w.bx;
      req.by        <= w.by;
      req.bz        <= w.bz;
      req.scalar_in <= w.s;
      do @(posedge clock); while (!req.ready);
      pending_results.push_back(compute_vector_op(w));
      op_hits[w.act]++;
      words_sent++;
      burst_left--;
   endtask

   // Stop offering words and wait until every expected word has come back.
   task automatic drain_pipeline();
      req.valid  <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic vec_word_type make_word(input logic [ACT_W-1:0] act,
                                              input data_type ax, ay, az, bx, by, bz, s);
      vec_word_type w;
      w.act = act;
      w.ax = ax; w.ay = ay; w.az = az;
      w.bx = bx; w.by = by; w.bz = bz;
      w.s = s;
      return w;
   endfunction

   // Operand values: full range, small fractions, extremes and mid-size values.
   function automatic data_type pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: return $urandom;
         3, 4:    return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         5: begin
            case ($urandom_range(0, 5))
               0: return DATA_MAX;
               1: return DATA_MIN;
               2: return '0;
               3: return -32'sd1;
               4: return 32'sd1 <<< FRAC;
               default: return -(32'sd1 <<< FRAC);
            endcase
         end
         default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic vec_word_type random_word();
      vec_word_type w;
      w = make_word(ACT_W'($urandom_range(0, 15)), pick_value(), pick_value(), pick_value(),
                    pick_value(), pick_value(), pick_value(), pick_value());
      // Steer some words into the interesting corners of certain operations.
      if (w.act == OP_EQUAL && $urandom_range(0, 1) == 0) begin
         w.bx = w.ax;
         w.by = w.ay;
         w.bz = ($urandom_range(0, 2) == 0) ? w.az ^ (32'd1 << $urandom_range(0, 31)) : w.az;
      end
      if (w.act == OP_DIVIDE && $urandom_range(0, 5) == 0) w.s = '0;
      if (w.act == OP_NORMALIZE && $urandom_range(0, 7) == 0) begin
         w.ax = '0;
         w.ay = '0;
         w.az = '0;
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Field extremes, every operation at least once, and the named special cases.
   task automatic test_directed();
      logic [ACT_W-1:0] code;
      send_word(make_word(OP_ADD, DATA_MAX, DATA_MIN, 32'sd5, DATA_MAX, DATA_MIN, -32'sd5, '0));
      send_word(make_word(OP_SUB, DATA_MIN, DATA_MAX, '0, DATA_MAX, DATA_MIN, '0, '0));
      send_word(make_word(OP_SCALE, DATA_MAX, DATA_MIN, -32'sd3, DATA_MIN, '0, '0, DATA_MIN));
      send_word(make_word(OP_SCALE, 32'sh0003_0000, -32'sh0001_8000, 32'sd1, '0, '0, '0,
                          32'sh0000_8000));
      // Divide by zero gives the zero vector without the flag.
      send_word(make_word(OP_DIVIDE, DATA_MAX, DATA_MIN, 32'sd7, '0, '0, '0, '0));
      send_word(make_word(OP_DIVIDE, DATA_MIN, 32'sh0001_0000, -32'sd7, '0, '0, '0, -32'sd1));
      send_word(make_word(OP_DOT, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                          '0));
      send_word(make_word(OP_DOT, -32'sd1, 32'sd1, '0, 32'sd1, 32'sd1, '0, '0));
      send_word(make_word(OP_CROSS, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN,
                          '0));
      send_word(make_word(OP_MAGNITUDE, DATA_MIN, DATA_MIN, DATA_MIN, '0, '0, '0, '0));
      send_word(make_word(OP_MAGNITUDE, 32'sh0003_0000, 32'sh0004_0000, '0, '0, '0, '0, '0));
      // Normalize of the zero vector, then of a vector whose magnitude clamps.
      send_word(make_word(OP_NORMALIZE, '0, '0, '0, '0, '0, '0, '0));
      send_word(make_word(OP_NORMALIZE, DATA_MAX, DATA_MAX, DATA_MIN, '0, '0, '0, '0));
      send_word(make_word(OP_NORMALIZE, 32'sd1, '0, '0, '0, '0, '0, '0));
      // Distance with a component difference beyond the 32-bit range.
      send_word(make_word(OP_DISTANCE, DATA_MIN, '0, '0, DATA_MAX, '0, '0, '0));
      send_word(make_word(OP_DISTANCE, 32'sh0001_0000, '0, '0, 32'sh0004_0000, 32'sh0004_0000,
                          '0, '0));
      // Negating the minimum value clamps.
      send_word(make_word(OP_NEGATE, DATA_MIN, DATA_MAX, '0, '0, '0, '0, '0));
      send_word(make_word(OP_EQUAL, 32'sd9, -32'sd9, DATA_MIN, 32'sd9, -32'sd9, DATA_MIN, '0));
      send_word(make_word(OP_EQUAL, 32'sd9, -32'sd9, DATA_MIN, 32'sd9, -32'sd9, DATA_MAX, '0));
      // Codes past the last operation.
      code = OP_EQUAL;
      send_word(make_word(code + 1'b1, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                          DATA_MAX, DATA_MAX));
      send_word(make_word('1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
      drain_pipeline();
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) send_word(random_word());
   endtask

   // Hold the receiver off long enough that the pipeline fills and req stalls.
   task automatic test_output_backpressure();
      hold_asks++;
      for (int i = 0; i < 150; i++) send_word(random_word());
      drain_pipeline();
   endtask

   // ------------------------------------------------------------------
   // Receiving side: random stall patterns plus the long hold-off.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_done != hold_asks) begin
         hold_done <= hold_asks;
         hold_cnt  <= LONG_HOLD;
         rsp.ready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(10, 120);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            0:       rsp.ready <= 1'b1;
            1:       rsp.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp.ready <= ~rsp.ready;
            default: rsp.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 30)
         $display("MISMATCH word %0d %s: got %h, expected %h", words_back, field, got, want);
   endtask

   // Every word taken on rsp is compared with the oldest expectation.
   always @(posedge clock) begin
      vec_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", rsp.rx, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp.rx !== want.rx) report_mismatch("rx", rsp.rx, want.rx);
            if (rsp.ry !== want.ry) report_mismatch("ry", rsp.ry, want.ry);
            if (rsp.rz !== want.rz) report_mismatch("rz", rsp.rz, want.rz);
            if (rsp.scalar_out !== want.sc) report_mismatch("scalar_out", rsp.scalar_out, want.sc);
            if (rsp.is_equal !== want.eq) report_mismatch("is_equal", rsp.is_equal, want.eq);
            if (rsp.saturated !== want.sat) report_mismatch("saturated", rsp.saturated, want.sat);
            if (want.sat) sat_seen++;
         end
         words_back++;
      end
   end

   // Watchdog: ends the run if no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired with %0d words outstanding", pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (op_hits[i]) op_hits[i] = 0;
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.action    = '0;
      req.ax        = '0;
      req.ay        = '0;
      req.az        = '0;
      req.bx        = '0;
      req.by        = '0;
      req.bz        = '0;
      req.scalar_in = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(250);
      test_output_backpressure();
      test_random_mix(220);
      drain_pipeline();

      if (pending_results.size() != 0) report_mismatch("words never returned", '0, '0);
      $display("Sent %0d words, checked %0d, %0d with saturation; %0d unused-code words.",
               words_sent, words_back, sat_seen,
               op_hits[11] + op_hits[12] + op_hits[13] + op_hits[14] + op_hits[15]);
      $display("Per-operation counts: add %0d sub %0d scale %0d div %0d dot %0d cross %0d",
               op_hits[OP_ADD], op_hits[OP_SUB], op_hits[OP_SCALE], op_hits[OP_DIVIDE],
               op_hits[OP_DOT], op_hits[OP_CROSS]);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/vfa_pkg.sv
hw/rtl/vfa_req_if.sv
hw/rtl/vfa_rsp_if.sv
hw/rtl/vfa_delay.sv
hw/rtl/vfa_lane.sv
hw/rtl/vfa_isqrt.sv
hw/rtl/vfa_div.sv
hw/rtl/vec3_fixed_alu.sv
dv/tb_top.sv
